>>> hdl/olid_pkg.sv
// Package for the ordered list insert/delete block: sizes, operation codes,
// cell control type. Depends on nothing; used by olid_cell and the top level.
package olid_pkg;

  localparam int unsigned DEPTH   = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned PLACE_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE     = 2'd2;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_SHIFT_IN  = 2'd1,  // take the left (front-side) neighbor
    CELL_SHIFT_OUT = 2'd2,  // take the right (back-side) neighbor
    CELL_LOAD      = 2'd3   // take the new value
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

>>> hdl/olid_cell.sv
// One storage cell of the list chain: holds a value, takes a neighbor's or
// a new value on command. Depends on olid_pkg.
module olid_cell (
  input  logic                                  clk_i,
  input  olid_pkg::cell_ctrl_t                  ctrl_i,
  input  logic signed [olid_pkg::VALUE_W-1:0]   left_i,
  input  logic signed [olid_pkg::VALUE_W-1:0]   right_i,
  input  logic signed [olid_pkg::VALUE_W-1:0]   load_i,
  output logic signed [olid_pkg::VALUE_W-1:0]   value_o
);

  logic signed [olid_pkg::VALUE_W-1:0] value_q;
  logic signed [olid_pkg::VALUE_W-1:0] value_d;

  always_comb begin
    case (ctrl_i.op)
      olid_pkg::CELL_SHIFT_IN:  value_d = left_i;
      olid_pkg::CELL_SHIFT_OUT: value_d = right_i;
      olid_pkg::CELL_LOAD:      value_d = load_i;
      default:                  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> hdl/ordered_list_insert_delete.sv
// An accepted word updates the list in its accept cycle; the result register
// then takes the first result word during the dump, and further results follow
// at one per cycle while the output side accepts them. No new input word is
// taken until the dump, a full rotation of the DEPTH-cell ring, is through,
// and a stalling output side lengthens it. Reset: rst_ni asynchronous, active
// low; clears count and control. Cell contents stay undefined until written.
module ordered_list_insert_delete (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: func[1:0], value[33:2], position[41:34], zero pad[47:42]
  input  logic [47:0] s_axis_tdata,
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: element[31:0], place[36:32], zero pad[39:37]
  output logic [39:0] m_axis_tdata,
  // tuser: empty_res[0], dropped[1]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_e;

  // Unpack the input word.
  logic [olid_pkg::FUNC_W-1:0]          in_func;
  logic signed [olid_pkg::VALUE_W-1:0]  in_value;
  logic [olid_pkg::POS_W-1:0]           in_pos;

  assign in_func  = s_axis_tdata[1:0];
  assign in_value = s_axis_tdata[33:2];
  assign in_pos   = s_axis_tdata[41:34];

  state_e                              state_q, state_d;
  logic [olid_pkg::CNT_W-1:0]          count_q, count_d;
  logic [olid_pkg::IDX_W-1:0]          idx_q, idx_d;
  logic                                drop_q, drop_d;

  logic                                out_valid_q, out_valid_d;
  logic signed [olid_pkg::VALUE_W-1:0] out_elem_q, out_elem_d;
  logic [olid_pkg::PLACE_W-1:0]        out_place_q, out_place_d;
  logic                                out_last_q, out_last_d;
  logic                                out_empty_q, out_empty_d;
  logic                                out_drop_q, out_drop_d;

  logic                                s_accept;
  logic                                full;
  logic                                list_empty;
  logic                                emit;
  logic                                out_free;
  logic                                step;

  olid_pkg::cell_ctrl_t                cell_ctrl [olid_pkg::DEPTH];
  logic signed [olid_pkg::VALUE_W-1:0] cell_val  [olid_pkg::DEPTH];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q >= olid_pkg::CNT_W'(olid_pkg::DEPTH));
  assign list_empty    = (count_q == '0);

  // During the dump the ring rotates toward the front once per step; cell 0
  // carries the element at place idx_q. Emit while idx_q is inside the list,
  // or once for an empty list.
  assign emit     = (state_q == S_DUMP) &&
                    ((list_empty && (idx_q == '0)) ||
                     (olid_pkg::CNT_W'(idx_q) < count_q));
  assign out_free = !out_valid_q || m_axis_tready;
  assign step     = (state_q == S_DUMP) && (!emit || out_free);

  // Per-cell commands: each cell decides from its own index.
  always_comb begin
    for (int i = 0; i < olid_pkg::DEPTH; i++) begin
      cell_ctrl[i].op = olid_pkg::CELL_HOLD;
      if (s_accept) begin
        case (in_func)
          olid_pkg::FUNC_PUSH_FRONT: begin
            // Shift everything back by one; cell 0 takes the new value.
            if (!full) cell_ctrl[i].op = olid_pkg::CELL_SHIFT_IN;
          end
          olid_pkg::FUNC_APPEND: begin
            if (!full && (olid_pkg::CNT_W'(i) == count_q)) begin
              cell_ctrl[i].op = olid_pkg::CELL_LOAD;
            end
          end
          olid_pkg::FUNC_DELETE: begin
            // Close the gap: cells at or behind the position take their successor.
            if ((olid_pkg::POS_W'(count_q) > in_pos) &&
                (olid_pkg::POS_W'(i) >= in_pos)) begin
              cell_ctrl[i].op = olid_pkg::CELL_SHIFT_OUT;
            end
          end
          default: cell_ctrl[i].op = olid_pkg::CELL_HOLD;
        endcase
      end else if (step) begin
        cell_ctrl[i].op = olid_pkg::CELL_SHIFT_OUT;
      end
    end
  end

  // The chain: cell 0 sees the input value on its left, the last cell sees
  // cell 0 on its right so that a full pass of DEPTH steps restores the order.
  for (genvar g = 0; g < olid_pkg::DEPTH; g++) begin : g_cell
    logic signed [olid_pkg::VALUE_W-1:0] left_v;
    logic signed [olid_pkg::VALUE_W-1:0] right_v;
    if (g == 0) begin : g_head
      assign left_v = in_value;
    end else begin : g_body
      assign left_v = cell_val[g-1];
    end
    if (g == olid_pkg::DEPTH - 1) begin : g_tail
      assign right_v = cell_val[0];
    end else begin : g_inner
      assign right_v = cell_val[g+1];
    end
    olid_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[g]),
      .left_i  (left_v),
      .right_i (right_v),
      .load_i  (in_value),
      .value_o (cell_val[g])
    );
  end

  // Sequencer and result register.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_elem_d  = out_elem_q;
    out_place_d = out_place_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_drop_d  = out_drop_q;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = S_DUMP;
          idx_d   = '0;
          drop_d  = 1'b0;
          case (in_func) inside
            olid_pkg::FUNC_PUSH_FRONT, olid_pkg::FUNC_APPEND: begin
              if (full) drop_d = 1'b1;
              else      count_d = count_q + olid_pkg::CNT_W'(1);
            end
            olid_pkg::FUNC_DELETE: begin
              if (olid_pkg::POS_W'(count_q) > in_pos) begin
                count_d = count_q - olid_pkg::CNT_W'(1);
              end
            end
            default: count_d = count_q;
          endcase
        end
      end
      S_DUMP: begin
        if (step) begin
          if (emit) begin
            out_valid_d = 1'b1;
            out_elem_d  = list_empty ? '0 : cell_val[0];
            out_place_d = olid_pkg::PLACE_W'(idx_q);
            out_last_d  = list_empty ||
                          ((olid_pkg::CNT_W'(idx_q) + olid_pkg::CNT_W'(1)) == count_q);
            out_empty_d = list_empty;
            out_drop_d  = drop_q;
          end
          idx_d = idx_q + olid_pkg::IDX_W'(1);
          if (idx_q == olid_pkg::IDX_W'(olid_pkg::DEPTH - 1)) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_elem_q  <= out_elem_d;
    out_place_q <= out_place_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_drop_q  <= out_drop_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_place_q, out_elem_q};
  assign m_axis_tuser  = {out_drop_q, out_empty_q};
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olid_pkg::CNT_W'(olid_pkg::DEPTH))
    else $error("count exceeds depth");

  a_accept_starts_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == S_DUMP) && (idx_q == '0))
    else $error("accepted word did not start a dump");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("empty result not marked last");

  a_no_accept_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !s_axis_tready)
    else $error("input ready during dump");

  a_count_stable_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DUMP) && $past(state_q == S_DUMP)) |-> $stable(count_q))
    else $error("count changed during dump");
`endif

endmodule
